// File: hdl/dwp_pkg.sv
// Shared types, constants and register codes of the weighted pixel predictor codec.
package dwp_pkg;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int HIST_BITS       = 2;
    localparam int COL_BITS        = 14;
    localparam int ROW_BITS        = 12;
    localparam int EFF_W_BITS      = 15;
    localparam int HEIGHT_BITS     = 13;
    localparam int DATA_BITS       = 16;
    localparam int ERR_BITS        = 19;
    localparam int PRED_BITS       = 22;
    localparam int QUO_BITS        = 21;
    localparam int CFG_IDX_BITS    = 3;
    localparam int MAX_HEIGHT      = 4096;

    localparam int C1         = 946;
    localparam int C2         = 724;
    localparam int C3         = 392;
    localparam int DCT_ROUND  = 1024;
    localparam int DCT_SHIFT  = 15;
    localparam int COEF_SHIFT = 6;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENCODE_MODE  = 3'd0,
        CFG_IMAGE_WIDTH  = 3'd1,
        CFG_IMAGE_HEIGHT = 3'd2,
        CFG_BIT_DEPTH    = 3'd3,
        CFG_MAX_VALUE    = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic                   encode;
        logic [EFF_W_BITS-1:0]  width;
        logic [HEIGHT_BITS-1:0] height;
        logic [DATA_BITS-1:0]   offset;
        logic [DATA_BITS-1:0]   maxv;
    } cfg_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] sample;
        logic [COL_BITS-1:0]  col;
        logic [ROW_BITS-1:0]  row;
        logic                 last;
        logic                 med;
    } item_t;

endpackage

// File: hdl/dct_weighted_pixel_predictor_codec.sv
// Top level of the weighted pixel predictor codec: registers, front end, queue, back end.
// MED pixels (first four rows or columns) go straight from the predictor to the result;
// interior pixels pass the 21-step restoring divider, skipped when both error weights are zero.
// The back end works on one request at a time while the front end queues up to two more.
// Reset clears the position counters, the left-pixel history, the queue and the result
// valid flag and loads the register defaults; the row and error stores are not cleared.
module dct_weighted_pixel_predictor_codec
    import dwp_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]    cfg_data,
    input  logic                    push,
    input  logic [DATA_BITS-1:0]    sample,
    output logic                    full,
    output logic                    empty,
    input  logic                    pop,
    output logic [DATA_BITS-1:0]    value,
    output logic                    last_of_frame
);

    logic                   encode_reg;
    logic [12:0]            width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [4:0]             depth_reg;
    logic [DATA_BITS-1:0]   maxv_reg;
    logic [4:0]             depth_eff;
    cfg_t                   cfg;

    logic  q_push, q_full, q_valid, q_pop;
    item_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encode_reg <= 1'b1;
            width_reg  <= 13'd512;
            height_reg <= 13'd512;
            depth_reg  <= 5'd8;
            maxv_reg   <= 16'd255;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_e'(cfg_index))
                CFG_ENCODE_MODE:  encode_reg <= cfg_data[0];
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[12:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[12:0];
                CFG_BIT_DEPTH:    depth_reg  <= cfg_data[4:0];
                CFG_MAX_VALUE:    maxv_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (depth_reg == '0)
        begin
            depth_eff = 5'd1;
        end
        else if (depth_reg > 5'(SAMPLE_BITS))
        begin
            depth_eff = 5'(SAMPLE_BITS);
        end
        else
        begin
            depth_eff = depth_reg;
        end
        cfg.encode = encode_reg;
        if (width_reg == '0)
        begin
            cfg.width = EFF_W_BITS'(1);
        end
        else if (EFF_W_BITS'(width_reg) > EFF_W_BITS'(MAX_WIDTH))
        begin
            cfg.width = EFF_W_BITS'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = EFF_W_BITS'(width_reg);
        end
        if (height_reg == '0)
        begin
            cfg.height = HEIGHT_BITS'(1);
        end
        else if (height_reg > HEIGHT_BITS'(MAX_HEIGHT))
        begin
            cfg.height = HEIGHT_BITS'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = height_reg;
        end
        cfg.offset = DATA_BITS'(1) << (depth_eff - 5'd1);
        cfg.maxv   = maxv_reg;
    end

    dwp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .push   (push),
        .sample (sample),
        .full   (full),
        .q_push (q_push),
        .q_item (q_in),
        .q_full (q_full)
    );

    dwp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (q_push),
        .in_item   (q_in),
        .in_full   (q_full),
        .out_valid (q_valid),
        .out_item  (q_out),
        .out_pop   (q_pop)
    );

    dwp_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_item        (q_out),
        .q_pop         (q_pop),
        .value         (value),
        .last_of_frame (last_of_frame),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

// File: hdl/dwp_front.sv
// Front end: takes requests, tracks the frame position and classifies each pixel.
module dwp_front
    import dwp_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] sample,
    output logic                 full,
    output logic                 q_push,
    output item_t                q_item,
    input  logic                 q_full
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [CW:0]         col_plus;
    logic [ROW_BITS:0]   row_plus;
    logic                wrap_col, wrap_row;

    assign full     = q_full;
    assign q_push   = push && !q_full;
    assign col_plus = {1'b0, col_reg} + 1'b1;
    assign row_plus = {1'b0, row_reg} + 1'b1;
    assign wrap_col = EFF_W_BITS'(col_plus) >= cfg.width;
    assign wrap_row = HEIGHT_BITS'(row_plus) >= cfg.height;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (wrap_col)
            begin
                col_next = '0;
                row_next = wrap_row ? '0 : row_plus[ROW_BITS-1:0];
            end
            else
            begin
                col_next = col_plus[CW-1:0];
            end
        end
    end

    always_comb
    begin
        q_item.sample = sample;
        q_item.col    = COL_BITS'(col_reg);
        q_item.row    = row_reg;
        q_item.last   = wrap_col && wrap_row;
        q_item.med    = (col_reg < CW'(4)) || (row_reg < ROW_BITS'(4));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: hdl/dwp_queue.sv
// Two-entry request queue between the front end and the back end.
module dwp_queue
    import dwp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_push,
    input  item_t in_item,
    output logic  in_full,
    output logic  out_valid,
    output item_t out_item,
    input  logic  out_pop
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign in_full   = count_reg == 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (in_push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (in_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (in_push && !out_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (out_pop && !in_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: hdl/dwp_back.sv
// Back end: row and error stores, predictors, weighted divider and result register.
module dwp_back
    import dwp_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic [DATA_BITS-1:0] value,
    output logic                 last_of_frame,
    output logic                 empty,
    input  logic                 pop
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = CW + HIST_BITS;
    localparam int PD = 4 * MAX_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_DCT1 = 9'b000000100,
        S_DCT2 = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_SUM  = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_CLIP = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic signed [23:0] a0;
        logic signed [23:0] a1;
        logic signed [23:0] a2;
        logic signed [23:0] a3;
    } dct_a_t;

    function automatic dct_a_t dct_stage1(input logic [15:0] s0, input logic [15:0] s1,
                                          input logic [15:0] s2, input logic [15:0] s3);
        logic signed [31:0] v0, v1, v2, v3, t1, t2, t3;
        dct_a_t r;
        v0 = $signed({16'd0, s0});
        v1 = $signed({16'd0, s1});
        v2 = $signed({16'd0, s2});
        v3 = $signed({16'd0, s3});
        t1 = 32'(C1) * (v0 - v3) + 32'(C3) * (v1 - v2);
        t2 = 32'(C2) * (v0 - v1 - v2 + v3);
        t3 = 32'(C1) * (v2 - v1) + 32'(C3) * (v0 - v3);
        r.a0 = 24'((v0 + v1 + v2 + v3 + 32'sd2) >>> 2);
        r.a1 = 24'(t1 >>> COEF_SHIFT);
        r.a2 = 24'(t2 >>> COEF_SHIFT);
        r.a3 = 24'(t3 >>> COEF_SHIFT);
        return r;
    endfunction

    function automatic logic signed [PRED_BITS-1:0] dct_stage2(input dct_a_t a);
        logic signed [39:0] t;
        t = -40'(C1) * 40'(a.a1) + 40'(C2) * 40'(a.a2) - 40'(C3) * 40'(a.a3)
            + 40'(DCT_ROUND);
        return PRED_BITS'(40'(a.a0) + (t >>> DCT_SHIFT));
    endfunction

    function automatic logic [DATA_BITS-1:0] clip(input logic signed [PRED_BITS-1:0] v,
                                                  input logic [DATA_BITS-1:0] hi);
        logic [DATA_BITS-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({6'd0, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[DATA_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [ERR_BITS-1:0] err_abs(input logic [ERR_BITS-1:0] e);
        return e[ERR_BITS-1] ? ERR_BITS'(-e) : e;
    endfunction

    logic [DATA_BITS-1:0] pix_mem [PD];
    logic [ERR_BITS-1:0]  hor_mem [MAX_WIDTH];
    logic [ERR_BITS-1:0]  ver_mem [MAX_WIDTH];

    state_t               state_reg;
    item_t                item_reg;
    logic [2:0]           rcnt_reg;
    logic [DATA_BITS-1:0] pix_rd_reg, up1_reg, up2_reg, up3_reg, up4_reg, upl_reg;
    logic [ERR_BITS-1:0]  hor_rd_reg, ver_rd_reg, eh_x_reg, eh_xm1_reg, ev_x_reg, ev_xm1_reg;
    logic [DATA_BITS-1:0] left_reg [4];
    dct_a_t               ha_reg, va_reg;
    logic signed [PRED_BITS-1:0] ph_reg, pv_reg;
    logic signed [42:0]   prod_h_reg, prod_v_reg;
    logic [QUO_BITS-1:0]  den_reg, q_reg;
    logic [43:0]          rem_reg;
    logic                 neg_reg;
    logic [4:0]           dcnt_reg;
    logic [DATA_BITS-1:0] pred_reg;
    logic                 out_valid_reg, out_last_reg;
    logic [DATA_BITS-1:0] out_value_reg;

    logic [CW-1:0]        x, xm1;
    logic [HIST_BITS-1:0] yslot, rd_slot;
    logic [AW-1:0]        pix_rd_addr, pix_wr_addr;
    logic [CW-1:0]        err_rd_addr;
    logic                 fin_go;

    logic [16:0]          ra, rb, rc, mx, mn;
    logic signed [PRED_BITS-1:0] med;
    logic [19:0]          wh, wv;
    logic signed [PRED_BITS:0] mean_sum;
    logic signed [43:0]   num;
    logic [43:0]          trial;
    logic signed [PRED_BITS-1:0] quo;

    logic [16:0]          range;
    logic signed [19:0]   e20, r20, half_s, hm_s, range_s, maxv_s;
    logic [DATA_BITS-1:0] enc_out, rx, store_val;
    logic signed [PRED_BITS:0] dh, dv;

    assign x     = item_reg.col[CW-1:0];
    assign xm1   = x - 1'b1;
    assign yslot = item_reg.row[HIST_BITS-1:0];

    always_comb
    begin
        case (rcnt_reg)
            3'd0:    rd_slot = yslot - HIST_BITS'(1);
            3'd1:    rd_slot = yslot - HIST_BITS'(1);
            3'd2:    rd_slot = yslot - HIST_BITS'(2);
            3'd3:    rd_slot = yslot - HIST_BITS'(3);
            default: rd_slot = yslot;
        endcase
    end

    assign pix_rd_addr = {rd_slot, (rcnt_reg == 3'd1) ? xm1 : x};
    assign err_rd_addr = (rcnt_reg == 3'd1) ? xm1 : x;
    assign pix_wr_addr = {yslot, x};
    assign fin_go      = (state_reg == S_FIN) && (!out_valid_reg || pop);
    assign q_pop       = (state_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            pix_mem[pix_wr_addr] <= store_val;
        end
        pix_rd_reg <= pix_mem[pix_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            hor_mem[x] <= dh[ERR_BITS-1:0];
            ver_mem[x] <= dv[ERR_BITS-1:0];
        end
        hor_rd_reg <= hor_mem[err_rd_addr];
        ver_rd_reg <= ver_mem[err_rd_addr];
    end

    always_comb
    begin
        if (item_reg.row == '0)
        begin
            rb = {1'b0, cfg.offset};
            rc = {1'b0, cfg.offset};
            ra = (x == '0) ? {1'b0, cfg.offset} : {1'b0, left_reg[0]};
        end
        else
        begin
            rb = {1'b0, up1_reg};
            ra = (x == '0) ? {1'b0, up1_reg} : {1'b0, left_reg[0]};
            rc = (x == '0) ? {1'b0, up1_reg} : {1'b0, upl_reg};
        end
        mx = (ra > rb) ? ra : rb;
        mn = (ra > rb) ? rb : ra;
        if (rc >= mx)
        begin
            med = PRED_BITS'(mn);
        end
        else if (rc <= mn)
        begin
            med = PRED_BITS'(mx);
        end
        else
        begin
            med = PRED_BITS'($signed({1'b0, ra}) + $signed({1'b0, rb}) - $signed({1'b0, rc}));
        end
    end

    always_comb
    begin
        wh       = 20'(err_abs(ev_xm1_reg)) + 20'(err_abs(ev_x_reg));
        wv       = 20'(err_abs(eh_xm1_reg)) + 20'(err_abs(eh_x_reg));
        mean_sum = (PRED_BITS+1)'(ph_reg) + (PRED_BITS+1)'(pv_reg);
        num      = 44'(prod_h_reg) + 44'(prod_v_reg);
        trial    = 44'(den_reg) << dcnt_reg;
        quo      = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    always_comb
    begin
        range   = {1'b0, cfg.maxv} + 17'd1;
        range_s = $signed({3'd0, range});
        half_s  = $signed({4'd0, range[16:1]});
        hm_s    = $signed({5'd0, cfg.maxv[15:1]});
        maxv_s  = $signed({4'd0, cfg.maxv});
        e20     = $signed({4'd0, item_reg.sample}) - $signed({4'd0, pred_reg});
        if (e20 < -half_s)
        begin
            e20 = e20 + range_s;
        end
        else if (e20 > hm_s)
        begin
            e20 = e20 - range_s;
        end
        enc_out = 16'(e20 + $signed({4'd0, cfg.offset}));
        r20     = $signed({4'd0, pred_reg}) + $signed({4'd0, item_reg.sample})
                  - $signed({4'd0, cfg.offset});
        if (r20 < 0)
        begin
            r20 = r20 + range_s;
        end
        else if (r20 > maxv_s)
        begin
            r20 = r20 - range_s;
        end
        if (cfg.encode)
        begin
            rx        = (item_reg.sample > cfg.maxv) ? cfg.maxv : item_reg.sample;
            store_val = item_reg.sample;
        end
        else
        begin
            rx        = clip(PRED_BITS'(r20), cfg.maxv);
            store_val = rx;
        end
        dh = $signed({7'd0, rx}) - (PRED_BITS+1)'(ph_reg);
        dv = $signed({7'd0, rx}) - (PRED_BITS+1)'(pv_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg <= q_item;
                end
            end
            S_READ:
            begin
                case (rcnt_reg)
                    3'd1:
                    begin
                        up1_reg  <= pix_rd_reg;
                        eh_x_reg <= hor_rd_reg;
                        ev_x_reg <= ver_rd_reg;
                    end
                    3'd2:
                    begin
                        upl_reg    <= pix_rd_reg;
                        eh_xm1_reg <= hor_rd_reg;
                        ev_xm1_reg <= ver_rd_reg;
                    end
                    3'd3:    up2_reg <= pix_rd_reg;
                    3'd4:    up3_reg <= pix_rd_reg;
                    3'd5:    up4_reg <= pix_rd_reg;
                    default: ;
                endcase
            end
            S_DCT1:
            begin
                if (item_reg.med)
                begin
                    ph_reg   <= med;
                    pv_reg   <= med;
                    pred_reg <= clip(med, cfg.maxv);
                end
                else
                begin
                    ha_reg <= dct_stage1(left_reg[3], left_reg[2], left_reg[1], left_reg[0]);
                    va_reg <= dct_stage1(up4_reg, up3_reg, up2_reg, up1_reg);
                end
            end
            S_DCT2:
            begin
                ph_reg <= dct_stage2(ha_reg);
                pv_reg <= dct_stage2(va_reg);
            end
            S_MUL:
            begin
                pred_reg   <= clip(PRED_BITS'(mean_sum >>> 1), cfg.maxv);
                prod_h_reg <= $signed({1'b0, wh}) * ph_reg;
                prod_v_reg <= $signed({1'b0, wv}) * pv_reg;
                den_reg    <= QUO_BITS'(wh) + QUO_BITS'(wv);
            end
            S_SUM:
            begin
                neg_reg <= num[43];
                rem_reg <= num[43] ? 44'(-num) : 44'(num);
                q_reg   <= '0;
            end
            S_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    q_reg   <= q_reg | (QUO_BITS'(1) << dcnt_reg);
                end
            end
            S_CLIP:
            begin
                pred_reg <= clip(quo, cfg.maxv);
            end
            default: ;
        endcase
        if (fin_go)
        begin
            out_value_reg <= cfg.encode ? enc_out : rx;
            out_last_reg  <= item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                left_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    rcnt_reg <= '0;
                    if (q_valid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    rcnt_reg <= rcnt_reg + 3'd1;
                    if (rcnt_reg == 3'd5)
                    begin
                        state_reg <= S_DCT1;
                    end
                end
                S_DCT1:
                begin
                    state_reg <= item_reg.med ? S_FIN : S_DCT2;
                end
                S_DCT2:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= (wh == '0 && wv == '0) ? S_FIN : S_SUM;
                end
                S_SUM:
                begin
                    dcnt_reg  <= 5'(QUO_BITS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 5'd1;
                    if (dcnt_reg == '0)
                    begin
                        state_reg <= S_CLIP;
                    end
                end
                S_CLIP:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        left_reg[3] <= left_reg[2];
                        left_reg[2] <= left_reg[1];
                        left_reg[1] <= left_reg[0];
                        left_reg[0] <= store_val;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign value         = out_value_reg;
    assign last_of_frame = out_last_reg;
    assign empty         = !out_valid_reg;

endmodule

// File: hdl/dwp_checker.sv
// Port-level checker of the weighted pixel predictor codec and its bind.
module dwp_checker
    import dwp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [DATA_BITS-1:0] value,
    input logic                 last_of_frame
);

    logic [2:0] pending_reg;
    logic       push_acc, pop_acc;

    assign push_acc = push && !full;
    assign pop_acc  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (push_acc && !pop_acc)
        begin
            pending_reg <= pending_reg + 3'd1;
        end
        else if (pop_acc && !push_acc)
        begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped before pop");

    a_stable_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(value) && $stable(last_of_frame))
        else $error("result changed while waiting");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != 3'd0)
        else $error("result without a pending request");

    a_full_backed: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> pending_reg >= 3'd2)
        else $error("full with fewer than two pending requests");

endmodule

bind dct_weighted_pixel_predictor_codec dwp_checker u_dwp_checker (.*);
